@@ rtl/lms_pkg.sv @@
// Shared constants and codes for the loudest microphone selector.
package lms_pkg;

   // Default sizes
   localparam int MIC_COUNT_DEF     = 8;
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int MAX_FRAME_DEF     = 1024;

   // Field widths
   localparam int LEVEL_W   = 16;
   localparam int STAMP_W   = 32;
   localparam int SAMPLE_W  = 16;
   localparam int MIC_IDX_W = 3;
   localparam int MASK_W    = 8;
   localparam int WINDOW_W  = 16;
   localparam int ROOT_W    = 32;

   // Beat kinds on the request tuser
   localparam logic REQ_AUDIO = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // Register indexes
   localparam logic CSR_MIC_ENABLE = 1'b0;
   localparam logic CSR_WINDOW     = 1'b1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2000;

endpackage

@@ rtl/lms_div.sv @@
// Restoring divider, one quotient bit per cycle.
module lms_div #(
   parameter int DW = 42,
   parameter int VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CTW = $clog2(DW + 1);

   logic [VW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [VW-1:0]  den_ff;
   logic [CTW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [VW:0]    trial;
   logic           fits;

   // One subtract-and-shift step
   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = fits ? VW'(trial - {1'b0, den_ff}) : VW'(trial);
      quo_in  = {quo_ff[DW-2:0], fits};
      cnt_in  = cnt_ff - CTW'(1);
      busy_in = busy_ff && (cnt_ff != CTW'(1));
      done_in = busy_ff && (cnt_ff == CTW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CTW'(DW);
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= busy_ff ? cnt_in : cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ rtl/lms_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module lms_isqrt
   import lms_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ROOT_W-1:0]  radicand,
   output logic               done,
   output logic [LEVEL_W-1:0] root
);
   logic [ROOT_W-1:0] v_ff, v_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W-1:0] bit_ff;
   logic [ROOT_W-1:0] trial;
   logic              busy_ff;
   logic              done_ff;

   // Digit-by-digit step
   always_comb begin
      trial = root_ff + bit_ff;
      if (v_ff >= trial) begin
         v_in    = v_ff - trial;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         v_in    = v_ff;
         root_in = root_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_ff && (bit_ff != ROOT_W'(1));
         done_ff <= busy_ff && (bit_ff == ROOT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= radicand;
         root_ff <= '0;
         bit_ff  <= ROOT_W'(1) << (ROOT_W - 2);
      end else if (busy_ff) begin
         v_ff    <= v_in;
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = root_ff[LEVEL_W-1:0];
endmodule

@@ rtl/loudest_mic_selector.sv @@
// Loudest microphone selector: frame RMS levels, windowed history, top pick.
//
// req channel: audio beats (tuser = 0) carry a microphone index and sample in
// tdata, tlast closes that microphone's frame; tick beats (tuser = 1) advance
// the time base. rsp channel: a beat per closed frame of an enabled microphone,
// with the winner. csr channel: index 0 = microphone enable mask, 1 = window in
// ticks; always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. A tick only advances the time base; a
// sample that does not close a frame is squared and accumulated. A closing
// sample then runs the shared divider and the square root unit and walks every
// enabled microphone with history: one history memory read per dropped entry
// plus one, and a divide for the mean. The single memory read port and the
// shared divider make the walk serial.
// Reset clears the tick count, accumulators and ring pointers, resets registers;
// history entries are only used inside a ring's fill, so need no clearing.
// A stalled result beat holds; the next frame result waits until it leaves, and
// requests are taken only while the controller is idle and no result is pending.
module loudest_mic_selector
   import lms_pkg::*;
#(
   parameter int MIC_COUNT     = MIC_COUNT_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int MAX_FRAME     = MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // mic_index[2:0], sample_value[18:3], zero pad
   input  logic        req_tuser,  // req_type
   input  logic        req_tlast,  // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // top_mic[2:0], top_mean_level[18:3], zero pad
   output logic        rsp_tuser,  // top_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   localparam int MW    = (MIC_COUNT > 1) ? $clog2(MIC_COUNT) : 1;
   localparam int CW    = $clog2(MAX_FRAME + 1);
   localparam int SUM_W = 31 + CW;
   localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW    = $clog2(HISTORY_DEPTH + 1);
   localparam int TW    = LEVEL_W + FW;
   localparam int DW    = (SUM_W > TW) ? SUM_W : TW;
   localparam int VW    = (CW > FW) ? CW : FW;
   localparam int SLOTS = MIC_COUNT * HISTORY_DEPTH;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EW    = STAMP_W + LEVEL_W;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_SQ        = 10'b0000000010,
      ST_ACC       = 10'b0000000100,
      ST_MS_GO     = 10'b0000001000,
      ST_MS_DIV    = 10'b0000010000,
      ST_SQRT      = 10'b0000100000,
      ST_P_CHECK   = 10'b0001000000,
      ST_P_EVAL    = 10'b0010000000,
      ST_MEAN_GO   = 10'b0100000000,
      ST_MEAN_WAIT = 10'b1000000000
   } state_type;

   // Result-pending flag sits beside the state register
   state_type state_ff, state_in;
   logic      out_pend_ff, out_pend_in;

   // Registers and per-microphone state
   logic [MASK_W-1:0]   mask_ff;
   logic [WINDOW_W-1:0] window_ff;
   logic [STAMP_W-1:0]  tick_ff;
   logic [SUM_W-1:0]    sum_ff   [MIC_COUNT];
   logic [CW-1:0]       count_ff [MIC_COUNT];
   logic [HW-1:0]       head_ff  [MIC_COUNT];
   logic [FW-1:0]       fill_ff  [MIC_COUNT];
   logic [TW-1:0]       total_ff [MIC_COUNT];

   logic [MW-1:0]       mic_ff, mic_in;
   logic [SAMPLE_W-1:0] mag_ff;
   logic [31:0]         sq_ff;
   logic                last_ff;
   logic [LEVEL_W-1:0]  top_level_ff, top_level_in;
   logic [MIC_IDX_W-1:0] top_mic_ff, top_mic_in;

   // Result beat register
   logic                 rsp_valid_ff;
   logic                 rsp_top_ff;
   logic [MIC_IDX_W-1:0] rsp_mic_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;

   // History memory
   logic [EW-1:0] hist_mem [SLOTS];
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata;
   logic [EW-1:0] mem_rdata_ff;

   // Arithmetic units
   logic               div_start, div_done;
   logic [DW-1:0]      div_dividend, div_q;
   logic [VW-1:0]      div_divisor;
   logic               sqrt_start, sqrt_done;
   logic [LEVEL_W-1:0] sqrt_root;

   // Current-microphone views
   logic [SUM_W-1:0] sum_cur;
   logic [CW-1:0]    count_cur;
   logic [HW-1:0]    head_cur, oldest;
   logic [FW-1:0]    fill_cur;
   logic [TW-1:0]    total_cur;
   logic [FW:0]      old_wide;
   logic [STAMP_W-1:0] age;
   logic             mic_en;
   logic             last_mic;
   logic             advance;
   logic             frame_close;

   // Input decode
   logic [MIC_IDX_W-1:0] in_mic;
   logic [SAMPLE_W-1:0]  in_sample;
   logic                 in_en;
   logic                 req_fire;

   assign in_mic    = req_tdata[2:0];
   assign in_sample = req_tdata[18:3];
   assign in_en     = ({1'b0, in_mic} < (MIC_IDX_W + 1)'(MIC_COUNT)) && mask_ff[in_mic];
   assign req_tready = (state_ff == ST_IDLE) && !out_pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign sum_cur   = sum_ff[mic_ff];
   assign count_cur = count_ff[mic_ff];
   assign head_cur  = head_ff[mic_ff];
   assign fill_cur  = fill_ff[mic_ff];
   assign total_cur = total_ff[mic_ff];
   assign mic_en    = mask_ff[mic_ff];
   assign last_mic  = mic_ff == MW'(MIC_COUNT - 1);
   assign age       = tick_ff - mem_rdata_ff[EW-1:LEVEL_W];

   // Oldest ring slot: head - fill modulo depth
   always_comb begin
      old_wide = (FW + 1)'(head_cur) + (FW + 1)'(HISTORY_DEPTH) - (FW + 1)'(fill_cur);
      if (old_wide >= (FW + 1)'(HISTORY_DEPTH)) begin
         old_wide = old_wide - (FW + 1)'(HISTORY_DEPTH);
      end
      oldest = HW'(old_wide);
   end

   // Memory access selection
   always_comb begin
      mem_re    = (state_ff == ST_MS_GO) ||
                  ((state_ff == ST_P_CHECK) && mic_en && (fill_cur != '0));
      mem_raddr = AW'(32'(mic_ff) * HISTORY_DEPTH +
                      32'((state_ff == ST_MS_GO) ? head_cur : oldest));
      frame_close = (state_ff == ST_SQRT) && sqrt_done;
      mem_we    = frame_close;
      mem_waddr = AW'(32'(mic_ff) * HISTORY_DEPTH + 32'(head_cur));
      mem_wdata = {tick_ff, sqrt_root};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= hist_mem[mem_raddr];
      end
   end

   // Divider operand selection
   always_comb begin
      div_start    = (state_ff == ST_MS_GO) || (state_ff == ST_MEAN_GO);
      div_dividend = (state_ff == ST_MS_GO) ? DW'(sum_cur) : DW'(total_cur);
      div_divisor  = (state_ff == ST_MS_GO) ? VW'(count_cur) : VW'(fill_cur);
      sqrt_start   = (state_ff == ST_MS_DIV) && div_done;
   end

   lms_div #(
      .DW (DW),
      .VW (VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   lms_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_q[ROOT_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Controller
   always_comb begin
      state_in     = state_ff;
      out_pend_in  = out_pend_ff;
      mic_in       = mic_ff;
      top_level_in = top_level_ff;
      top_mic_in   = top_mic_ff;
      advance      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_AUDIO) && in_en) begin
               mic_in   = MW'(in_mic);
               state_in = ST_SQ;
            end
         end
         ST_SQ: state_in = ST_ACC;
         ST_ACC: state_in = last_ff ? ST_MS_GO : ST_IDLE;
         ST_MS_GO: state_in = ST_MS_DIV;
         ST_MS_DIV: begin
            if (div_done) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               mic_in       = '0;
               top_level_in = '0;
               top_mic_in   = '0;
               state_in     = ST_P_CHECK;
            end
         end
         ST_P_CHECK: begin
            if (mic_en && (fill_cur != '0)) begin
               state_in = ST_P_EVAL;
            end else begin
               advance = 1'b1;
            end
         end
         ST_P_EVAL: state_in = (age > STAMP_W'(window_ff)) ? ST_P_CHECK : ST_MEAN_GO;
         ST_MEAN_GO: state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: begin
            if (div_done) begin
               if (div_q[LEVEL_W-1:0] > top_level_ff) begin
                  top_level_in = div_q[LEVEL_W-1:0];
                  top_mic_in   = MIC_IDX_W'(mic_ff);
               end
               advance = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (advance) begin
         if (last_mic) begin
            out_pend_in = 1'b1;
            state_in    = ST_IDLE;
         end else begin
            mic_in   = mic_ff + MW'(1);
            state_in = ST_P_CHECK;
         end
      end
      // Pending result leaves once the beat register is free
      if (out_pend_ff && (!rsp_valid_ff || rsp_tready)) begin
         out_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_pend_ff <= out_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mic_ff       <= mic_in;
      top_level_ff <= top_level_in;
      top_mic_ff   <= top_mic_in;
      if (req_fire) begin
         mag_ff  <= in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : in_sample;
         last_ff <= req_tlast;
      end
      sq_ff <= 32'(mag_ff) * 32'(mag_ff);
   end

   // Result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_pend_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_pend_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_top_ff   <= top_level_ff != '0;
         rsp_mic_ff   <= top_mic_ff;
         rsp_level_ff <= top_level_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_top_ff;
   assign rsp_tdata  = {5'd0, rsp_level_ff, rsp_mic_ff};

   // Time base, registers and per-microphone accumulators and ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         mask_ff   <= '0;
         window_ff <= WINDOW_RESET;
         for (int m = 0; m < MIC_COUNT; m++) begin
            sum_ff[m]   <= '0;
            count_ff[m] <= '0;
            head_ff[m]  <= '0;
            fill_ff[m]  <= '0;
            total_ff[m] <= '0;
         end
      end else begin
         if (req_fire && (req_tuser == REQ_TICK)) begin
            tick_ff <= tick_ff + STAMP_W'(1);
         end
         // Accumulate the square, capped at the frame limit
         if ((state_ff == ST_ACC) && (count_cur != CW'(MAX_FRAME))) begin
            sum_ff[mic_ff]   <= sum_cur + SUM_W'(sq_ff);
            count_ff[mic_ff] <= count_cur + CW'(1);
         end
         // Store the frame level, overwriting the oldest when full
         if (frame_close) begin
            sum_ff[mic_ff]   <= '0;
            count_ff[mic_ff] <= '0;
            head_ff[mic_ff]  <= (head_cur == HW'(HISTORY_DEPTH - 1)) ?
                                '0 : head_cur + HW'(1);
            if (fill_cur == FW'(HISTORY_DEPTH)) begin
               total_ff[mic_ff] <= total_cur + TW'(sqrt_root) -
                                   TW'(mem_rdata_ff[LEVEL_W-1:0]);
            end else begin
               total_ff[mic_ff] <= total_cur + TW'(sqrt_root);
               fill_ff[mic_ff]  <= fill_cur + FW'(1);
            end
         end
         // Drop an entry that aged out of the window
         if ((state_ff == ST_P_EVAL) && (age > STAMP_W'(window_ff))) begin
            fill_ff[mic_ff]  <= fill_cur - FW'(1);
            total_ff[mic_ff] <= total_cur - TW'(mem_rdata_ff[LEVEL_W-1:0]);
         end
         // Register writes; disabling a microphone empties its state
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIC_ENABLE: begin
                  mask_ff <= csr_data[MASK_W-1:0];
                  for (int m = 0; m < MIC_COUNT; m++) begin
                     if (mask_ff[m] && !csr_data[m]) begin
                        sum_ff[m]   <= '0;
                        count_ff[m] <= '0;
                        head_ff[m]  <= '0;
                        fill_ff[m]  <= '0;
                        total_ff[m] <= '0;
                     end
                  end
               end
               CSR_WINDOW: window_ff <= csr_data;
               default: window_ff <= window_ff;
            endcase
         end
      end
   end
endmodule

@@ dv/tb.sv @@
// Testbench for loudest_mic_selector: directed and random stream traffic.
`timescale 1ns / 100ps

module tb
   import lms_pkg::*;
();

   localparam int MICS   = 8;
   localparam int DEPTH  = 64;
   localparam int FRAMEMAX = 1024;
   localparam int SETTLE = 40;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic                 found;
      logic [MIC_IDX_W-1:0] mic;
      logic [LEVEL_W-1:0]   level;
   } winner_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   loudest_mic_selector u_dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   logic [31:0]          now_ticks;
   logic [63:0]          energy [MICS];
   logic [31:0]          n_samples [MICS];
   logic [LEVEL_W-1:0]   ring_level [MICS*DEPTH];
   logic [31:0]          ring_stamp [MICS*DEPTH];
   int unsigned          ring_head [MICS];
   int unsigned          ring_fill [MICS];
   logic [MASK_W-1:0]    enabled;
   logic [WINDOW_W-1:0]  window_len;

   winner_type winner_q[$];
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles = 0;

   function automatic logic [31:0] int_sqrt(logic [31:0] v);
      logic [31:0] root, bit_w;
      root  = 0;
      bit_w = 32'h4000_0000;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v    = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   task automatic empty_mic(int m);
      energy[m]    = 0;
      n_samples[m] = 0;
      ring_head[m] = 0;
      ring_fill[m] = 0;
   endtask

   // Model one accepted request beat; queues the winner when an enabled microphone's frame closes
   task automatic predict_beat(logic kind, logic [2:0] mic, logic [15:0] smp, logic last);
      logic [31:0] mag, ms, age;
      logic [63:0] total;
      int unsigned slot, oldest, idx, mean;
      winner_type w;
      if (kind == REQ_TICK) begin
         now_ticks++;
         return;
      end
      if (!enabled[mic]) return;
      mag = smp[15] ? 32'(-$signed({16'hFFFF, smp})) : {16'h0, smp};
      if (n_samples[mic] < FRAMEMAX) begin
         energy[mic] += 64'(mag) * 64'(mag);
         n_samples[mic]++;
      end
      if (!last) return;
      ms   = 32'(energy[mic] / n_samples[mic]);
      slot = mic * DEPTH + ring_head[mic];
      ring_level[slot] = LEVEL_W'(int_sqrt(ms));
      ring_stamp[slot] = now_ticks;
      ring_head[mic]   = (ring_head[mic] + 1) % DEPTH;
      if (ring_fill[mic] < DEPTH) ring_fill[mic]++;
      energy[mic]    = 0;
      n_samples[mic] = 0;
      w = '0;
      for (int m = 0; m < MICS; m++) begin
         if (!enabled[m]) continue;
         while (ring_fill[m] > 0) begin
            oldest = (ring_head[m] + DEPTH - ring_fill[m]) % DEPTH;
            age = now_ticks - ring_stamp[m*DEPTH + oldest];
            if (age > {16'h0, window_len}) ring_fill[m]--;
            else break;
         end
         total = 0;
         for (int k = 0; k < ring_fill[m]; k++) begin
            idx = (ring_head[m] + DEPTH - ring_fill[m] + k) % DEPTH;
            total += ring_level[m*DEPTH + idx];
         end
         mean = (ring_fill[m] > 0) ? int'(total / ring_fill[m]) : 0;
         if (mean > w.level) begin
            w.level = LEVEL_W'(mean);
            w.mic   = 3'(m);
         end
      end
      w.found = (w.level > 0);
      winner_q = {winner_q, w};
   endtask

   // Send one request beat; valid stays high after acceptance unless a gap follows
   task automatic send_beat(logic kind, logic [2:0] mic, logic [15:0] smp, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, smp, mic};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beat(kind, mic, smp, last);
   endtask

   task automatic send_sample(logic [2:0] mic, logic [15:0] smp, logic last);
      send_beat(REQ_AUDIO, mic, smp, last);
   endtask

   task automatic send_tick();
      send_beat(REQ_TICK, 3'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // Wait until every expected result has come and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (winner_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MIC_ENABLE) begin
         for (int m = 0; m < MICS; m++)
            if (enabled[m] && !value[m]) empty_mic(m);
         enabled = value[MASK_W-1:0];
      end else begin
         window_len = value;
      end
   endtask

   // One frame of random content on one microphone
   task automatic send_frame(logic [2:0] mic, int len);
      for (int i = 0; i < len; i++) send_sample(mic, 16'($urandom), i == len - 1);
   endtask

   // Result checker
   always @(posedge clock) begin
      winner_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tuser;
            got.mic   = rsp_tdata[2:0];
            got.level = rsp_tdata[18:3];
            if (winner_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: valid=%0d mic=%0d level=%0d",
                           got.found, got.mic, got.level);
            end else begin
               want = winner_q.pop_front();
               if (got !== want || rsp_tdata[23:19] !== 5'b0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp v=%0d mic=%0d lvl=%0d got v=%0d mic=%0d lvl=%0d pad=%0h",
                              want.found, want.mic, want.level,
                              got.found, got.mic, got.level, rsp_tdata[23:19]);
               end
            end
         end
      end
   end

   // Watchdog on beats of any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Extremes of the sample field, disabled microphones, silent frames
   task automatic test_directed();
      write_csr(CSR_WINDOW, 16'hFFFF);
      write_csr(CSR_MIC_ENABLE, 16'h000F);
      send_sample(3'd0, 16'h7FFF, 1'b1);
      send_sample(3'd1, 16'h8000, 1'b0);
      send_sample(3'd1, 16'h8000, 1'b1);
      send_sample(3'd2, 16'h0000, 1'b1);
      send_sample(3'd5, 16'h7FFF, 1'b1);
      send_tick();
      send_sample(3'd3, 16'h0001, 1'b0);
      send_sample(3'd3, 16'hFFFF, 1'b0);
      send_sample(3'd3, 16'h5555, 1'b0);
      send_sample(3'd3, 16'hAAAA, 1'b1);
      send_sample(3'd7, 16'h1234, 1'b0);
      send_tick();
      send_sample(3'd2, 16'h0001, 1'b1);
      // disabling clears history and any open frame
      send_sample(3'd0, 16'h4000, 1'b0);
      write_csr(CSR_MIC_ENABLE, 16'h000E);
      write_csr(CSR_MIC_ENABLE, 16'h00FF);
      send_sample(3'd0, 16'h0100, 1'b1);
      send_sample(3'd7, 16'h8001, 1'b1);
      write_csr(CSR_MIC_ENABLE, 16'h0000);
      send_sample(3'd4, 16'h7FFF, 1'b1);
   endtask

   // Frame longer than the accumulator limit
   task automatic test_long_frame();
      write_csr(CSR_MIC_ENABLE, 16'h0001);
      send_frame(3'd0, FRAMEMAX + 6);
   endtask

   // History ring wraps and overwrites its oldest entries
   task automatic test_ring_wrap();
      write_csr(CSR_MIC_ENABLE, 16'h0006);
      for (int i = 0; i < DEPTH + 8; i++) send_frame(3'd1, 1);
      send_frame(3'd2, 2);
   endtask

   // Short windows: levels age out as ticks pass
   task automatic test_window();
      write_csr(CSR_MIC_ENABLE, 16'h00FF);
      write_csr(CSR_WINDOW, 16'd1);
      for (int i = 0; i < 12; i++) begin
         send_frame(3'($urandom_range(7)), $urandom_range(1, 3));
         repeat ($urandom_range(0, 2)) send_tick();
      end
      write_csr(CSR_WINDOW, 16'd3);
      for (int i = 0; i < 12; i++) begin
         send_frame(3'($urandom_range(7)), $urandom_range(1, 3));
         repeat ($urandom_range(0, 3)) send_tick();
      end
   endtask

   // Random traffic, mostly whole frames, some noise
   task automatic test_random(int send_pct, int stall_pct, int beats, bit pause_midway);
      int sent;
      logic [15:0] win;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      case ($urandom_range(3))
         0: win = 16'($urandom_range(1, 4));
         1: win = 16'($urandom_range(5, 60));
         2: win = 16'hFFFF;
         default: win = 16'($urandom);
      endcase
      if (win == 0) win = 16'd1;
      write_csr(CSR_WINDOW, win);
      write_csr(CSR_MIC_ENABLE, ($urandom_range(3) == 0) ? 16'h00FF : 16'($urandom_range(1, 255)));
      sent = 0;
      while (sent < beats) begin
         if (pause_midway && sent >= beats / 2) begin
            drain();
            pause_midway = 0;
         end
         if ($urandom_range(99) < 85) begin
            int len;
            logic [2:0] mic;
            len = $urandom_range(1, 6);
            mic = 3'($urandom_range(7));
            send_frame(mic, len);
            sent += len;
            if ($urandom_range(2) == 0) begin
               send_tick();
               sent++;
            end
         end else begin
            send_beat(1'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      now_ticks  = 0;
      enabled    = '0;
      window_len = WINDOW_RESET;
      for (int m = 0; m < MICS; m++) empty_mic(m);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_long_frame();
      test_ring_wrap();
      test_window();
      test_random(0, 0, 64, 0);
      test_random(53, 0, 64, 1);
      test_random(0, 53, 64, 0);
      test_random(32, 32, 64, 0);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && winner_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
